>>> src/cfd_pkg.sv
// ============================================================================
// CRC-16 framed deframer package
// Shared types, constants and the byte-wide CRC-16/CCITT-FALSE update.
// ============================================================================
package cfd_pkg;

    // CRC-16/CCITT-FALSE constants.
    localparam logic [15:0] CRC_INIT = 16'hFFFF;
    localparam logic [15:0] CRC_POLY = 16'h1021;

    // Result kinds.
    localparam logic KIND_PAYLOAD = 1'b0;
    localparam logic KIND_FRAME_END = 1'b1;

    // Position within the frame, named after the byte that is expected next.
    typedef enum logic [2:0] {
        PH_TYPE     = 3'd0,
        PH_SEQUENCE = 3'd1,
        PH_LENGTH   = 3'd2,
        PH_PAYLOAD  = 3'd3,
        PH_CRC_LO   = 3'd4,
        PH_CRC_HI   = 3'd5
    } t_phase;

    // One result transaction.
    typedef struct packed {
        logic       kind;
        logic [7:0] payload_byte;
        logic [7:0] payload_index;
        logic [7:0] frame_type;
        logic [7:0] sequence_number;
        logic [7:0] frame_length;
        logic       crc_ok;
    } t_result;

    // Parser outcome for the byte it currently holds.
    typedef struct packed {
        logic    has_result;
        t_result result;
    } t_parse;

    // MSB-first CRC update over one byte, eight bit steps unrolled.
    function automatic logic [15:0] crc16_byte(input logic [15:0] crc_in,
                                               input logic [7:0]  data);
        logic [15:0] c;
        c = crc_in ^ {data, 8'h00};
        for (int i = 0; i < 8; i++) begin
            if (c[15]) begin
                c = {c[14:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[14:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

>>> src/cfd_in_if.sv
// ============================================================================
// Byte input channel
// Valid/ready channel that carries one raw frame stream byte.
// ============================================================================
interface cfd_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

>>> src/cfd_out_if.sv
// ============================================================================
// Result output channel
// Valid/ready channel that carries one payload byte or frame end result.
// ============================================================================
interface cfd_out_if;
    logic       valid;
    logic       ready;
    logic       kind;
    logic [7:0] payload_byte;
    logic [7:0] payload_index;
    logic [7:0] frame_type;
    logic [7:0] sequence_number;
    logic [7:0] frame_length;
    logic       crc_ok;

    modport source (
        output valid, output kind, output payload_byte, output payload_index,
        output frame_type, output sequence_number, output frame_length,
        output crc_ok, input ready
    );
    modport sink (
        input valid, input kind, input payload_byte, input payload_index,
        input frame_type, input sequence_number, input frame_length,
        input crc_ok, output ready
    );
endinterface

>>> src/cfd_in_stage.sv
// ============================================================================
// Deframer input register
// Captures one byte per cycle while empty or draining, and holds it until the parser consumes it.
// ============================================================================
module cfd_in_stage
    import cfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cfd_in_if.sink     i_rx,
    input  logic       i_advance,
    output logic       o_valid,
    output logic [7:0] o_byte
);

    logic       r_valid;
    logic       n_valid;
    logic [7:0] r_byte;
    logic       load;

    // A new transaction is taken when the register is empty or drains now.
    assign i_rx.ready = !r_valid || i_advance;
    assign load       = i_rx.valid && i_rx.ready;

    always_comb begin
        n_valid = r_valid;
        if (load) begin
            n_valid = 1'b1;
        end else if (i_advance) begin
            n_valid = 1'b0;
        end
    end

    // Valid flag with reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // Byte register, no reset needed.
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

>>> src/cfd_parser.sv
// ============================================================================
// Deframer frame parser
// Tracks the frame position, header fields and running CRC, and forms the
// result for the byte held in the input register.
// ============================================================================
module cfd_parser
    import cfd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic [7:0] i_byte,
    input  logic       i_advance,
    output t_parse     o_parse
);

    t_phase      r_phase, n_phase;
    logic [7:0]  r_type, n_type;
    logic [7:0]  r_seq, n_seq;
    logic [7:0]  r_len, n_len;
    logic [7:0]  r_seen, n_seen;
    logic [15:0] r_crc, n_crc;
    logic [7:0]  r_crc_lo, n_crc_lo;
    logic [15:0] crc_upd;
    logic [7:0]  seen_inc;

    assign crc_upd  = crc16_byte((r_phase == PH_PAYLOAD) ? r_crc : CRC_INIT, i_byte);
    assign seen_inc = r_seen + 8'd1;

    // Next state and the result for the held byte.
    always_comb begin
        n_phase  = r_phase;
        n_type   = r_type;
        n_seq    = r_seq;
        n_len    = r_len;
        n_seen   = r_seen;
        n_crc    = r_crc;
        n_crc_lo = r_crc_lo;

        o_parse                        = '0;
        o_parse.result.frame_type      = r_type;
        o_parse.result.sequence_number = r_seq;
        o_parse.result.frame_length    = r_len;

        case (r_phase)
            PH_SEQUENCE: begin
                n_seq   = i_byte;
                n_phase = PH_LENGTH;
            end
            PH_LENGTH: begin
                n_len   = i_byte;
                n_seen  = 8'd0;
                n_phase = (i_byte == 8'd0) ? PH_CRC_LO : PH_PAYLOAD;
            end
            PH_PAYLOAD: begin
                n_crc                        = crc_upd;
                n_seen                       = seen_inc;
                o_parse.has_result           = 1'b1;
                o_parse.result.kind          = KIND_PAYLOAD;
                o_parse.result.payload_byte  = i_byte;
                o_parse.result.payload_index = r_seen;
                if (seen_inc >= r_len) begin
                    n_phase = PH_CRC_LO;
                end
            end
            PH_CRC_LO: begin
                n_crc_lo = i_byte;
                n_phase  = PH_CRC_HI;
            end
            PH_CRC_HI: begin
                o_parse.has_result     = 1'b1;
                o_parse.result.kind    = KIND_FRAME_END;
                o_parse.result.crc_ok  = ({i_byte, r_crc_lo} == r_crc);
                n_phase                = PH_TYPE;
            end
            default: begin
                // Type byte; unused phase codes also land here.
                n_type   = i_byte;
                n_seq    = 8'd0;
                n_len    = 8'd0;
                n_seen   = 8'd0;
                n_crc_lo = 8'd0;
                n_crc    = crc_upd;
                n_phase  = PH_SEQUENCE;
            end
        endcase
    end

    // Frame state registers, updated when the held byte is consumed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= PH_TYPE;
            r_type   <= 8'd0;
            r_seq    <= 8'd0;
            r_len    <= 8'd0;
            r_seen   <= 8'd0;
            r_crc    <= CRC_INIT;
            r_crc_lo <= 8'd0;
        end else if (i_advance) begin
            r_phase  <= n_phase;
            r_type   <= n_type;
            r_seq    <= n_seq;
            r_len    <= n_len;
            r_seen   <= n_seen;
            r_crc    <= n_crc;
            r_crc_lo <= n_crc_lo;
        end
    end

endmodule

>>> src/crc16_framed_deframer.sv
// ============================================================================
// CRC-16 framed deframer
// Splits a byte stream of length-prefixed frames, checks CRC-16/CCITT-FALSE.
// ============================================================================
// Usage:
//   i_rx carries the raw stream, one byte per transaction. A frame is type,
//   sequence, payload length, the payload bytes and a two byte CRC, low byte
//   first. The CRC covers the type byte and the payload.
//   o_res carries one transaction per payload byte (kind 0, with its index)
//   and one per frame (kind 1, after the CRC high byte) with crc_ok.
//   Header and CRC low bytes produce no output transaction.
//   Throughput is one byte per cycle while o_res is not stalled. A byte taken
//   from i_rx sits in the input register and is parsed combinationally from
//   there; if it yields a result, that result is registered in the output
//   register, which drives o_res.valid until the sink takes it.
//   The per-byte CRC update feeds the parser's running CRC register.
//   When o_res stalls, the input register keeps accepting until a byte that
//   yields a result finds the output register full; then i_rx.ready drops.
//   An incomplete frame simply waits for more bytes. Synchronous reset
//   empties both registers and returns the parser to the type byte.
// ============================================================================
module crc16_framed_deframer
    import cfd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    cfd_in_if.sink  i_rx,
    cfd_out_if.source o_res
);

    logic       hold_valid;
    logic [7:0] hold_byte;
    logic       advance;
    logic       out_free;
    t_parse     parse;
    logic       r_out_valid;
    logic       n_out_valid;
    t_result    r_out;

    cfd_in_stage u_in_stage (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rx      (i_rx),
        .i_advance (advance),
        .o_valid   (hold_valid),
        .o_byte    (hold_byte)
    );

    cfd_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_byte    (hold_byte),
        .i_advance (advance),
        .o_parse   (parse)
    );

    // The held byte is consumed unless its result has nowhere to go.
    assign out_free = !r_out_valid || o_res.ready;
    assign advance  = hold_valid && (!parse.has_result || out_free);

    always_comb begin
        n_out_valid = r_out_valid && !o_res.ready;
        if (advance && parse.has_result) begin
            n_out_valid = 1'b1;
        end
    end

    // Output valid flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= n_out_valid;
        end
    end

    // Output payload register.
    always_ff @(posedge i_clk) begin
        if (advance && parse.has_result) begin
            r_out <= parse.result;
        end
    end

    assign o_res.valid           = r_out_valid;
    assign o_res.kind            = r_out.kind;
    assign o_res.payload_byte    = r_out.payload_byte;
    assign o_res.payload_index   = r_out.payload_index;
    assign o_res.frame_type      = r_out.frame_type;
    assign o_res.sequence_number = r_out.sequence_number;
    assign o_res.frame_length    = r_out.frame_length;
    assign o_res.crc_ok          = r_out.crc_ok;

endmodule
